// ===== hw/rtl/sst_pkg.sv =====
// ----------------------------------------------------------------------------
// Scoped symbol table package
// Shared types and codes for the block-structured symbol table.
// ----------------------------------------------------------------------------
package sst_pkg;

  localparam int MAX_BLOCKS_DEF = 16;
  localparam int ENTRIES_DEF    = 64;

  localparam logic [2:0] OP_DEFINE = 3'd0;
  localparam logic [2:0] OP_SEARCH = 3'd1;
  localparam logic [2:0] OP_FIND   = 3'd2;
  localparam logic [2:0] OP_OPEN   = 3'd3;
  localparam logic [2:0] OP_CLOSE  = 3'd4;

  localparam logic [2:0] STS_OK        = 3'd0;
  localparam logic [2:0] STS_NOT_FOUND = 3'd1;
  localparam logic [2:0] STS_OVERFLOW  = 3'd2;
  localparam logic [2:0] STS_FULL      = 3'd3;
  localparam logic [2:0] STS_NO_BLOCK  = 3'd4;

  typedef struct packed {
    logic [2:0]         operation;
    logic [15:0]        key;
    logic [3:0]         kind;
    logic [3:0]         sym_type;
    logic [15:0]        size;
    logic signed [31:0] value;
    logic [3:0]         lex_level;
    logic [15:0]        displacement;
    logic [15:0]        start_address;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [3:0]         found_kind;
    logic [3:0]         found_type;
    logic [15:0]        found_size;
    logic signed [31:0] found_value;
    logic [3:0]         found_level;
    logic [15:0]        found_displacement;
    logic [15:0]        found_start;
    logic [4:0]         block_depth;
  } out_word_t;

  // Everything stored for one symbol apart from its key.
  typedef struct packed {
    logic [3:0]         kind;
    logic [3:0]         sym_type;
    logic [15:0]        size;
    logic signed [31:0] value;
    logic [3:0]         lex_level;
    logic [15:0]        displacement;
    logic [15:0]        start_address;
  } sym_attr_t;

endpackage

// ===== hw/rtl/scoped_symbol_table_top.sv =====
// ----------------------------------------------------------------------------
// Scoped symbol table
// Block-structured compiler symbol table with a stack of nested blocks.
// ----------------------------------------------------------------------------
//
//   Channel   Ports                      Handshake
//   --------  -------------------------  ---------------------------------
//   input     start, busy, in_word       word taken when start & !busy
//   result    out_valid, out_word        one-cycle strobe, cannot stall
//
// Define, open, close, refused lookups and unused codes finish at once:
// the result word appears on the cycle after the command is taken. Search
// and find scan the key memory backward from the newest entry, one entry per
// cycle, pausing at every block boundary crossed; a find that hits then
// passes through S_FETCH and S_RESP to read the matched entry. Reset clears
// the block and entry counters and the sequencer state; the memories hold
// stale words that are never used. The receiver cannot stall the result
// strobe, so busy only reflects a running search or find.
//
// All entries live in one flat store in definition order. Each open block
// records the entry count at its opening, so closing a block simply rolls
// the entry count back. Scanning backward, the last match seen inside a
// block is its earliest one, and the scan stops at the first block boundary
// once a hit is held (find) or at the innermost boundary (search).
// ----------------------------------------------------------------------------
module scoped_symbol_table_top
  import sst_pkg::*;
#(
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int ENTRIES    = ENTRIES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_word_t  in_word,
  output logic      out_valid,
  output out_word_t out_word
);

  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int BIDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int DEPTH_W = $clog2(MAX_BLOCKS + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_FETCH = 2'd2;
  localparam logic [1:0] S_RESP  = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [DEPTH_W-1:0] open_r, open_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [BIDX_W-1:0]  blk_r, blk_nxt;
  logic [ADDR_W-1:0]  hit_r, hit_nxt;
  logic               hit_vld_r, hit_vld_nxt;
  logic               is_find_r, is_find_nxt;
  logic [15:0]        key_r, key_nxt;
  logic               out_vld_r, out_vld_nxt;
  out_word_t          out_r, out_nxt;

  // Block start memory: one entry per nesting level, holding the entry count
  // at the moment the block was opened. Its read port follows blk_nxt so
  // that bs_q_r always holds the start of the block in blk_r.
  logic [CNT_W-1:0]   start_mem [MAX_BLOCKS];
  logic [CNT_W-1:0]   bs_q_r;
  logic               bs_we;
  logic [BIDX_W-1:0]  bs_waddr;

  logic               ent_we;
  logic [15:0]        key_rdata;
  sym_attr_t          attr_rdata;
  sym_attr_t          wattr;
  logic [ADDR_W-1:0]  key_raddr;

  logic               emit;
  logic [2:0]         sts;
  logic               blk_full;
  logic               tbl_full;

  assign blk_full = (open_r == DEPTH_W'(MAX_BLOCKS));
  assign tbl_full = (count_r == CNT_W'(ENTRIES));
  assign bs_waddr = BIDX_W'(open_r);

  always_comb begin
    state_nxt   = state_r;
    open_nxt    = open_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    blk_nxt     = blk_r;
    hit_nxt     = hit_r;
    hit_vld_nxt = hit_vld_r;
    is_find_nxt = is_find_r;
    key_nxt     = key_r;
    out_nxt     = out_r;
    out_vld_nxt = 1'b0;
    emit        = 1'b0;
    sts         = STS_OK;
    bs_we       = 1'b0;
    ent_we      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          emit = 1'b1;
          case (in_word.operation)
            OP_DEFINE: begin
              if (open_r == '0) begin
                sts = STS_NO_BLOCK;
              end else if (tbl_full) begin
                sts = STS_FULL;
              end else begin
                ent_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_SEARCH, OP_FIND: begin
              if (open_r == '0) begin
                sts = STS_NO_BLOCK;
              end else begin
                emit        = 1'b0;
                state_nxt   = S_SCAN;
                idx_nxt     = count_r;
                hit_vld_nxt = 1'b0;
                is_find_nxt = (in_word.operation == OP_FIND);
                key_nxt     = in_word.key;
              end
            end
            OP_OPEN: begin
              if (blk_full) begin
                sts = STS_OVERFLOW;
              end else begin
                bs_we    = 1'b1;
                open_nxt = open_r + DEPTH_W'(1);
              end
            end
            OP_CLOSE: begin
              if (open_r == '0) begin
                sts = STS_NO_BLOCK;
              end else begin
                open_nxt  = open_r - DEPTH_W'(1);
                count_nxt = bs_q_r;
              end
            end
            default: begin
              sts = STS_OK;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (idx_r == '0) begin
          if (hit_vld_r && is_find_r) begin
            state_nxt = S_FETCH;
          end else begin
            emit      = 1'b1;
            sts       = hit_vld_r ? STS_OK : STS_NOT_FOUND;
            state_nxt = S_IDLE;
          end
        end else if (idx_r <= bs_q_r) begin
          // The next entry belongs to an outer block.
          if (hit_vld_r || !is_find_r || blk_r == '0) begin
            if (hit_vld_r && is_find_r) begin
              state_nxt = S_FETCH;
            end else begin
              emit      = 1'b1;
              sts       = hit_vld_r ? STS_OK : STS_NOT_FOUND;
              state_nxt = S_IDLE;
            end
          end else begin
            blk_nxt = blk_r - BIDX_W'(1);
          end
        end else begin
          if (key_rdata == key_r) begin
            hit_nxt     = ADDR_W'(idx_r - CNT_W'(1));
            hit_vld_nxt = 1'b1;
          end
          idx_nxt = idx_r - CNT_W'(1);
        end
      end

      S_FETCH: begin
        state_nxt = S_RESP;
      end

      S_RESP: begin
        state_nxt = S_IDLE;
        emit      = 1'b1;
        sts       = STS_OK;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Whenever the sequencer is idle next, the block pointer sits on the
    // innermost block, so bs_q_r is ready for the next command.
    if (state_nxt == S_IDLE) begin
      blk_nxt = (open_nxt == '0) ? '0 : BIDX_W'(open_nxt - DEPTH_W'(1));
    end

    if (emit) begin
      out_vld_nxt             = 1'b1;
      out_nxt                 = '0;
      out_nxt.status          = sts;
      out_nxt.block_depth     = 5'(open_nxt);
      if (state_r == S_RESP) begin
        out_nxt.found_kind         = attr_rdata.kind;
        out_nxt.found_type         = attr_rdata.sym_type;
        out_nxt.found_size         = attr_rdata.size;
        out_nxt.found_value        = attr_rdata.value;
        out_nxt.found_level        = attr_rdata.lex_level;
        out_nxt.found_displacement = attr_rdata.displacement;
        out_nxt.found_start        = attr_rdata.start_address;
      end
    end
  end

  // The scan reads the key of the entry just below the next index, so the
  // key of entry idx_r - 1 is waiting in the read register during each scan cycle.
  assign key_raddr = ADDR_W'(idx_nxt - CNT_W'(1));

  always_comb begin
    wattr.kind          = in_word.kind;
    wattr.sym_type      = in_word.sym_type;
    wattr.size          = in_word.size;
    wattr.value         = in_word.value;
    wattr.lex_level     = in_word.lex_level;
    wattr.displacement  = in_word.displacement;
    wattr.start_address = in_word.start_address;
  end

  sst_entry_store #(
    .ENTRIES (ENTRIES)
  ) u_store (
    .clk        (clk),
    .we         (ent_we),
    .waddr      (ADDR_W'(count_r)),
    .wkey       (in_word.key),
    .wattr      (wattr),
    .key_raddr  (key_raddr),
    .key_rdata  (key_rdata),
    .attr_raddr (hit_r),
    .attr_rdata (attr_rdata)
  );

  // Block start memory with write-first behavior on a same-address read,
  // which happens when a block is opened and becomes the innermost one.
  always_ff @(posedge clk) begin
    if (bs_we) begin
      start_mem[bs_waddr] <= count_r;
    end
    if (bs_we && (bs_waddr == blk_nxt)) begin
      bs_q_r <= count_r;
    end else begin
      bs_q_r <= start_mem[blk_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      open_r    <= '0;
      count_r   <= '0;
      out_vld_r <= 1'b0;
      idx_r     <= '0;
      blk_r     <= '0;
      hit_vld_r <= 1'b0;
      is_find_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      open_r    <= open_nxt;
      count_r   <= count_nxt;
      out_vld_r <= out_vld_nxt;
      idx_r     <= idx_nxt;
      blk_r     <= blk_nxt;
      hit_vld_r <= hit_vld_nxt;
      is_find_r <= is_find_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
    key_r <= key_nxt;
    out_r <= out_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_vld_r;
  assign out_word  = out_r;

endmodule

// ===== hw/rtl/sst_entry_store.sv =====
// ----------------------------------------------------------------------------
// Symbol entry store
// Key, attribute, value and place memories with one write port, a key read
// port for the scan and an attribute read port for the matched entry.
// ----------------------------------------------------------------------------
module sst_entry_store
  import sst_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF,
  localparam int ADDR_W = $clog2(ENTRIES)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [15:0]       wkey,
  input  sym_attr_t         wattr,
  input  logic [ADDR_W-1:0] key_raddr,
  output logic [15:0]       key_rdata,
  input  logic [ADDR_W-1:0] attr_raddr,
  output sym_attr_t         attr_rdata
);

  logic [15:0] key_mem   [ENTRIES];
  logic [27:0] attr_mem  [ENTRIES];
  logic [31:0] value_mem [ENTRIES];
  logic [31:0] place_mem [ENTRIES];

  logic [15:0] key_q_r;
  logic [27:0] attr_q_r;
  logic [31:0] value_q_r;
  logic [31:0] place_q_r;

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr]   <= wkey;
      attr_mem[waddr]  <= {wattr.lex_level, wattr.size, wattr.sym_type, wattr.kind};
      value_mem[waddr] <= wattr.value;
      place_mem[waddr] <= {wattr.start_address, wattr.displacement};
    end
    key_q_r   <= key_mem[key_raddr];
    attr_q_r  <= attr_mem[attr_raddr];
    value_q_r <= value_mem[attr_raddr];
    place_q_r <= place_mem[attr_raddr];
  end

  assign key_rdata = key_q_r;

  always_comb begin
    attr_rdata.kind          = attr_q_r[3:0];
    attr_rdata.sym_type      = attr_q_r[7:4];
    attr_rdata.size          = attr_q_r[23:8];
    attr_rdata.lex_level     = attr_q_r[27:24];
    attr_rdata.value         = value_q_r;
    attr_rdata.displacement  = place_q_r[15:0];
    attr_rdata.start_address = place_q_r[31:16];
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scoped symbol table testbench
// Drives command words into the block-structured symbol table in random
// bursts and checks every result word against a cycle-free predictor of the
// table. A directed preamble covers the corner cases. Random episodes follow:
// deep nesting to overflow, filling the table, and mixed traffic.
// ----------------------------------------------------------------------------
module testbench;
  import sst_pkg::*;

  // About 900 words, even with the slowest finds and the random gaps between
  // bursts, stay far below this limit.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_WORDS  = 860;
  localparam int SETTLE_CYCLES = 100;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_word_t  in_word = '0;
  logic      busy;
  logic      out_valid;
  out_word_t out_word;

  scoped_symbol_table_top uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Reset is held at the start of the run and never again.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
  end

  // --------------------------------------------------------------------------
  // Predictor state: a flat symbol store in definition order. Each open scope
  // records the symbol count at the moment it was opened.
  // --------------------------------------------------------------------------
  logic [15:0] sym_keys  [ENTRIES_DEF];
  sym_attr_t   sym_attrs [ENTRIES_DEF];
  int          scope_base[MAX_BLOCKS_DEF];
  int          scope_depth = 0;
  int          sym_count = 0;

  in_word_t    pending_cmds[$];  // command words not yet taken by the block
  out_word_t   due_results[$];   // predicted result words, oldest first
  int          queued = 0;
  int          errors = 0;
  int          cycles = 0;
  logic [15:0] key_pool[8];

  // Applies one command to the predicted table and returns the result word
  // that the block must produce for it.
  function automatic out_word_t apply_command(in_word_t w);
    out_word_t r;
    int        hit;
    int        lo;
    int        hi;
    int        b;
    int        i;
    r = '0;
    r.status = STS_OK;
    hit = -1;
    case (w.operation)
      OP_DEFINE: begin
        if (scope_depth == 0) begin
          r.status = STS_NO_BLOCK;
        end else if (sym_count >= ENTRIES_DEF) begin
          r.status = STS_FULL;
        end else begin
          sym_keys[sym_count]  = w.key;
          sym_attrs[sym_count] = {w.kind, w.sym_type, w.size, w.value, w.lex_level,
                                  w.displacement, w.start_address};
          sym_count++;
        end
      end
      OP_SEARCH: begin
        // Only the innermost scope counts, and a hit reports no attributes.
        if (scope_depth == 0) begin
          r.status = STS_NO_BLOCK;
        end else begin
          r.status = STS_NOT_FOUND;
          for (i = scope_base[scope_depth - 1]; i < sym_count; i++)
            if (sym_keys[i] == w.key) r.status = STS_OK;
        end
      end
      OP_FIND: begin
        // Walk outward; within a scope the earliest definition wins.
        if (scope_depth == 0) begin
          r.status = STS_NO_BLOCK;
        end else begin
          r.status = STS_NOT_FOUND;
          hi = sym_count;
          for (b = scope_depth; b > 0 && hit < 0; b--) begin
            lo = scope_base[b - 1];
            for (i = lo; i < hi && hit < 0; i++)
              if (sym_keys[i] == w.key) hit = i;
            hi = lo;
          end
          if (hit >= 0) begin
            r.status             = STS_OK;
            r.found_kind         = sym_attrs[hit].kind;
            r.found_type         = sym_attrs[hit].sym_type;
            r.found_size         = sym_attrs[hit].size;
            r.found_value        = sym_attrs[hit].value;
            r.found_level        = sym_attrs[hit].lex_level;
            r.found_displacement = sym_attrs[hit].displacement;
            r.found_start        = sym_attrs[hit].start_address;
          end
        end
      end
      OP_OPEN: begin
        if (scope_depth >= MAX_BLOCKS_DEF) begin
          r.status = STS_OVERFLOW;
        end else begin
          scope_base[scope_depth] = sym_count;
          scope_depth++;
        end
      end
      OP_CLOSE: begin
        // Closing a scope drops its symbols by rolling the count back.
        if (scope_depth == 0) begin
          r.status = STS_NO_BLOCK;
        end else begin
          scope_depth--;
          sym_count = scope_base[scope_depth];
        end
      end
      default: begin
        // Unused operation codes change nothing and report success.
      end
    endcase
    r.block_depth = 5'(scope_depth);
    return r;
  endfunction

  // Most keys come from a small pool so that lookups hit, shadow and repeat.
  function automatic logic [15:0] pick_key();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return key_pool[$urandom_range(0, 7)];
  endfunction

  // A command word with random attributes. One word in eight uses the
  // short form, with level, displacement and start address all zero.
  function automatic in_word_t rand_cmd(logic [2:0] op, logic [15:0] key);
    in_word_t w;
    w.operation     = op;
    w.key           = key;
    w.kind          = 4'($urandom);
    w.sym_type      = 4'($urandom);
    w.size          = 16'($urandom);
    w.value         = $urandom;
    w.lex_level     = 4'($urandom);
    w.displacement  = 16'($urandom);
    w.start_address = 16'($urandom);
    if ($urandom_range(0, 7) == 0) begin
      w.lex_level     = '0;
      w.displacement  = '0;
      w.start_address = '0;
    end
    return w;
  endfunction

  task automatic push_cmd(in_word_t w);
    pending_cmds.insert(pending_cmds.size(), w);
    queued++;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus. Every command word is queued at time zero; the driver below
  // feeds the words to the block once reset is released.
  // --------------------------------------------------------------------------
  initial begin
    in_word_t w;
    int       episode;
    int       mode;
    int       n;
    int       r;
    foreach (key_pool[k]) key_pool[k] = 16'($urandom);

    // With no scope open, every lookup, define and close is refused.
    push_cmd(rand_cmd(OP_FIND, 16'h0000));
    push_cmd(rand_cmd(OP_SEARCH, 16'h0000));
    push_cmd(rand_cmd(OP_DEFINE, 16'h0000));
    push_cmd(rand_cmd(OP_CLOSE, 16'h0000));
    // The three unused operation codes.
    for (n = 1; n <= 3; n++) push_cmd(rand_cmd(OP_CLOSE + 3'(n), 16'($urandom)));

    push_cmd(rand_cmd(OP_OPEN, 16'h0000));
    // Field extremes: an all-zero define, an all-ones define, and the most
    // negative value.
    w = '0;
    w.operation = OP_DEFINE;
    push_cmd(w);
    w = '1;
    w.operation = OP_DEFINE;
    push_cmd(w);
    w = rand_cmd(OP_DEFINE, 16'h8000);
    w.value = 32'sh8000_0000;
    push_cmd(w);
    // A short-form define, then the same key defined again: lookups must
    // return the first of the two.
    w = rand_cmd(OP_DEFINE, 16'h1234);
    w.lex_level     = '0;
    w.displacement  = '0;
    w.start_address = '0;
    push_cmd(w);
    push_cmd(rand_cmd(OP_DEFINE, 16'h1234));
    push_cmd(rand_cmd(OP_SEARCH, 16'h1234));
    push_cmd(rand_cmd(OP_SEARCH, 16'h4321));
    push_cmd(rand_cmd(OP_FIND, 16'h1234));

    // An inner scope shadows one key and leaves the others to the outer one.
    push_cmd(rand_cmd(OP_OPEN, 16'h0000));
    push_cmd(rand_cmd(OP_DEFINE, 16'hFFFF));
    push_cmd(rand_cmd(OP_SEARCH, 16'h0000));
    push_cmd(rand_cmd(OP_FIND, 16'h0000));
    push_cmd(rand_cmd(OP_FIND, 16'hFFFF));
    push_cmd(rand_cmd(OP_FIND, 16'h7777));
    push_cmd(rand_cmd(OP_CLOSE, 16'h0000));
    push_cmd(rand_cmd(OP_FIND, 16'hFFFF));
    push_cmd(rand_cmd(OP_CLOSE, 16'h0000));

    // Random episodes. The first is always a nest deep enough to overflow
    // the scope stack, and the second always fills the table past its end.
    n = queued + RANDOM_WORDS;
    for (episode = 0; queued < n; episode++) begin
      mode = (episode < 2) ? episode : $urandom_range(0, 9);
      case (mode)
        0: begin
          r = (episode == 0) ? 18 : $urandom_range(12, 19);
          repeat (r) begin
            push_cmd(rand_cmd(OP_OPEN, pick_key()));
            if ($urandom_range(0, 2) == 0) push_cmd(rand_cmd(OP_DEFINE, pick_key()));
          end
          repeat ($urandom_range(4, 10))
            push_cmd(rand_cmd(($urandom_range(0, 2) == 0) ? OP_SEARCH : OP_FIND, pick_key()));
          // A couple of extra closes run into the empty stack.
          repeat (r + 2) begin
            push_cmd(rand_cmd(OP_CLOSE, pick_key()));
            if ($urandom_range(0, 3) == 0) push_cmd(rand_cmd(OP_FIND, pick_key()));
          end
        end
        1: begin
          repeat (2) push_cmd(rand_cmd(OP_OPEN, pick_key()));
          repeat ((episode == 1) ? 66 : $urandom_range(30, 66)) begin
            push_cmd(rand_cmd(OP_DEFINE, pick_key()));
            if ($urandom_range(0, 3) == 0)
              push_cmd(rand_cmd(($urandom_range(0, 1) == 0) ? OP_SEARCH : OP_FIND,
                                pick_key()));
          end
          repeat (6) push_cmd(rand_cmd(OP_FIND, pick_key()));
          repeat (3) push_cmd(rand_cmd(OP_CLOSE, pick_key()));
        end
        default: begin
          repeat ($urandom_range(20, 60)) begin
            r = $urandom_range(0, 99);
            if (r < 35)      push_cmd(rand_cmd(OP_DEFINE, pick_key()));
            else if (r < 52) push_cmd(rand_cmd(OP_SEARCH, pick_key()));
            else if (r < 75) push_cmd(rand_cmd(OP_FIND, pick_key()));
            else if (r < 87) push_cmd(rand_cmd(OP_OPEN, pick_key()));
            else if (r < 97) push_cmd(rand_cmd(OP_CLOSE, pick_key()));
            else push_cmd(rand_cmd(OP_CLOSE + 3'($urandom_range(1, 3)), pick_key()));
          end
        end
      endcase
    end

    // Wait until every word is taken and every result has come back, then
    // give the block a little longer to show any stray result.
    @(posedge clk);
    while (!(rst_n && pending_cmds.size() == 0 && !start && due_results.size() == 0))
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_cmds.size() != 0 || due_results.size() != 0) begin
      $display("%0t: words outstanding, expected 0, actual %0d", $time,
               pending_cmds.size() + due_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver. A word is taken at an edge where start is high and busy is low;
  // that is when its result is predicted. The sender works in bursts of
  // random length with random gaps between them, and an occasional long
  // burst runs with no gaps at all.
  // --------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left = 0;

  always @(posedge clk) begin
    logic go;
    go = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        due_results.insert(due_results.size(), apply_command(in_word));
      end
      // A word that the block has not taken yet stays on the port.
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() > 0) begin
          in_word <= pending_cmds.pop_front();
          go = 1'b1;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 160)
                                                     : $urandom_range(1, 24);
            gap_left   = $urandom_range(0, 8);
          end
        end
        start <= go;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor. Results cannot be held off, so every strobe is checked against
  // the oldest predicted result word, one field at a time.
  // --------------------------------------------------------------------------
  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && $isunknown(out_valid)) begin
      $display("%0t: out_valid unknown, expected 0 or 1, actual %b", $time, out_valid);
      errors++;
    end else if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        $display("%0t: result word with none expected, expected nothing, actual %h",
                 $time, out_word);
        errors++;
      end else begin
        want = due_results.pop_front();
        compare_field("status", 32'(want.status), 32'(out_word.status));
        compare_field("found_kind", 32'(want.found_kind), 32'(out_word.found_kind));
        compare_field("found_type", 32'(want.found_type), 32'(out_word.found_type));
        compare_field("found_size", 32'(want.found_size), 32'(out_word.found_size));
        compare_field("found_value", want.found_value, out_word.found_value);
        compare_field("found_level", 32'(want.found_level), 32'(out_word.found_level));
        compare_field("found_displacement", 32'(want.found_displacement),
                      32'(out_word.found_displacement));
        compare_field("found_start", 32'(want.found_start), 32'(out_word.found_start));
        compare_field("block_depth", 32'(want.block_depth), 32'(out_word.block_depth));
      end
    end
  end

  // A hung handshake ends the run here.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule

// ===== files.f =====
hw/rtl/sst_pkg.sv
hw/rtl/sst_entry_store.sv
hw/rtl/scoped_symbol_table_top.sv
bench/testbench.sv
